### hdl/kcv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcv_pkg: shared types and constants of the constant-velocity Kalman filter
// Formats, datapath operation codes, operand selects and saturation helper.
// ----------------------------------------------------------------------------
package kcv_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int SAT_W = (VALUE_WIDTH < 24) ? 24 : ((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH);

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 31;
    localparam int FRAC    = 24;
    localparam int ACC_W   = 48;
    localparam int DEN_W   = 34;
    localparam int NUM_W   = DATA_W + FRAC;
    localparam int DIV_STEPS = NUM_W;
    localparam int PC_W    = 6;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam logic signed [DATA_W-1:0] ONE_Q24 = DATA_W'(32'sd16777216);

    localparam logic [CFG_W-1:0] TIME_STEP_RESET         = CFG_W'(167772);
    localparam logic [CFG_W-1:0] PROCESS_NOISE_RESET     = CFG_W'(16777);
    localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RESET = CFG_W'(167772);

    typedef enum logic [1:0] {
        CFG_TIME_STEP         = 2'd0,
        CFG_PROCESS_NOISE     = 2'd1,
        CFG_MEASUREMENT_NOISE = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_LOAD  = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_MULT  = 4'd4,
        OP_MACC  = 4'd5,
        OP_MSUB  = 4'd6,
        OP_STORE = 4'd7,
        OP_DIV   = 4'd8,
        OP_END   = 4'd9
    } op_t;

    typedef enum logic [4:0] {
        SRC_ZERO = 5'd0,
        SRC_ONE  = 5'd1,
        SRC_Z    = 5'd2,
        SRC_DT   = 5'd3,
        SRC_Q    = 5'd4,
        SRC_R    = 5'd5,
        SRC_POS  = 5'd6,
        SRC_VEL  = 5'd7,
        SRC_CPP  = 5'd8,
        SRC_CPV  = 5'd9,
        SRC_CVP  = 5'd10,
        SRC_CVV  = 5'd11,
        SRC_DT2  = 5'd12,
        SRC_P00  = 5'd13,
        SRC_P01  = 5'd14,
        SRC_P10  = 5'd15,
        SRC_P11  = 5'd16,
        SRC_K0   = 5'd17,
        SRC_K1   = 5'd18,
        SRC_RES  = 5'd19,
        SRC_OMK  = 5'd20
    } src_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        src_t d;
    } instr_t;

    typedef struct packed {
        logic   latch;
        logic   publish;
        instr_t instr;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

    typedef struct packed {
        logic              clip;
        logic [DATA_W-1:0] val;
    } sat_t;

    function automatic sat_t sat_wide(input logic signed [63:0] v);
        sat_t r;
        if (v > SAT_HI)
        begin
            r.clip = 1'b1;
            r.val  = SAT_HI[DATA_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r.clip = 1'b1;
            r.val  = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            r.clip = 1'b0;
            r.val  = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/kcv_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcv_if: channel interfaces of the Kalman filter
// Measurement channel and estimate channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface kcv_meas_if
    import kcv_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] measurement;
    logic                     restart;

    modport source (output valid, measurement, restart, input ready);
    modport sink (input valid, measurement, restart, output ready);
endinterface

interface kcv_est_if
    import kcv_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] position_estimate;
    logic signed [DATA_W-1:0] velocity_estimate;
    logic                     saturated;

    modport source (output valid, position_estimate, velocity_estimate, saturated,
                    input ready);
    modport sink (input valid, position_estimate, velocity_estimate, saturated,
                  output ready);
endinterface
`default_nettype wire

### hdl/kcv_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcv_divider: dual-lane restoring divider for the two Kalman gains
// Both numerators share one denominator; one quotient bit per cycle per lane.
// ----------------------------------------------------------------------------
module kcv_divider
    import kcv_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [ACC_W-1:0]  den,
    input  wire logic signed [DATA_W-1:0] num0,
    input  wire logic signed [DATA_W-1:0] num1,
    output logic                          done,
    output logic [DATA_W-1:0]             q0,
    output logic [DATA_W-1:0]             q1,
    output logic                          clip
);

    logic              busy_reg;
    logic [PC_W-1:0]   cnt_reg;
    logic              done_reg;
    logic [DEN_W-1:0]  d_reg;
    logic [NUM_W-1:0]  n0_reg, n1_reg;
    logic [DEN_W-1:0]  r0_reg, r1_reg;
    logic              neg0_reg, neg1_reg, zero_reg;
    logic [DATA_W-1:0] q0_reg, q1_reg;
    logic              clip_reg;

    logic [ACC_W-1:0]  den_mag;
    logic [DATA_W-1:0] num0_mag, num1_mag;
    logic [DEN_W:0]    trial0, trial1;
    logic              ge0, ge1;
    logic [DEN_W:0]    diff0, diff1;
    sat_t              s0, s1;

    always_comb
    begin
        den_mag  = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
        num0_mag = num0[DATA_W-1] ? DATA_W'(-num0) : DATA_W'(num0);
        num1_mag = num1[DATA_W-1] ? DATA_W'(-num1) : DATA_W'(num1);
        trial0   = {r0_reg, n0_reg[NUM_W-1]};
        trial1   = {r1_reg, n1_reg[NUM_W-1]};
        ge0      = trial0 >= {1'b0, d_reg};
        ge1      = trial1 >= {1'b0, d_reg};
        diff0    = trial0 - {1'b0, d_reg};
        diff1    = trial1 - {1'b0, d_reg};
        s0 = sat_wide(neg0_reg ? -$signed({{(64-NUM_W){1'b0}}, n0_reg})
                               : $signed({{(64-NUM_W){1'b0}}, n0_reg}));
        s1 = sat_wide(neg1_reg ? -$signed({{(64-NUM_W){1'b0}}, n1_reg})
                               : $signed({{(64-NUM_W){1'b0}}, n1_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= PC_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg    <= den_mag[DEN_W-1:0];
            zero_reg <= (den == '0);
            neg0_reg <= num0[DATA_W-1] ^ den[ACC_W-1];
            neg1_reg <= num1[DATA_W-1] ^ den[ACC_W-1];
            n0_reg   <= {num0_mag, {FRAC{1'b0}}} + NUM_W'(den_mag[DEN_W-1:1]);
            n1_reg   <= {num1_mag, {FRAC{1'b0}}} + NUM_W'(den_mag[DEN_W-1:1]);
            r0_reg   <= '0;
            r1_reg   <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            r0_reg <= ge0 ? diff0[DEN_W-1:0] : trial0[DEN_W-1:0];
            r1_reg <= ge1 ? diff1[DEN_W-1:0] : trial1[DEN_W-1:0];
            n0_reg <= {n0_reg[NUM_W-2:0], ge0};
            n1_reg <= {n1_reg[NUM_W-2:0], ge1};
        end
        else if (busy_reg)
        begin
            q0_reg   <= zero_reg ? '0 : s0.val;
            q1_reg   <= zero_reg ? '0 : s1.val;
            clip_reg <= !zero_reg && (s0.clip || s1.clip);
        end
    end

    assign done = done_reg;
    assign q0   = q0_reg;
    assign q1   = q1_reg;
    assign clip = clip_reg;

endmodule
`default_nettype wire

### hdl/kcv_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcv_datapath: operand registers, multiplier, accumulator and gain divider
// Executes one command per cycle; holds state, covariance and configuration.
// ----------------------------------------------------------------------------
module kcv_datapath
    import kcv_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    output status_t                       status,
    input  wire logic signed [DATA_W-1:0] measurement,
    input  wire logic                     restart,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    output logic signed [DATA_W-1:0]      position_estimate,
    output logic signed [DATA_W-1:0]      velocity_estimate,
    output logic                          saturated
);

    logic [CFG_W-1:0]         dt_reg, q_reg, r_reg;
    logic signed [DATA_W-1:0] pos_reg, vel_reg, cpp_reg, cpv_reg, cvp_reg, cvv_reg;
    logic                     primed_reg;
    logic signed [DATA_W-1:0] z_reg, dt2_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [DATA_W-1:0] k0_reg, k1_reg, res_reg, omk_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [63:0]              prod_reg;
    logic                     pneg_reg;
    logic                     flag_reg;
    logic signed [DATA_W-1:0] pe_reg, ve_reg;
    logic                     se_reg;

    logic signed [DATA_W-1:0] a_val, b_val;
    logic [DATA_W-1:0]        a_mag, b_mag;
    logic [63:0]              rnd_sum;
    logic signed [ACC_W-1:0]  term;
    sat_t                     st;
    logic                     div_done;
    logic [DATA_W-1:0]        dq0, dq1;
    logic                     dclip;

    function automatic logic signed [DATA_W-1:0] pick(input src_t s,
        input logic signed [DATA_W-1:0] z, input logic [CFG_W-1:0] dt,
        input logic [CFG_W-1:0] q, input logic [CFG_W-1:0] r,
        input logic signed [DATA_W-1:0] pos, input logic signed [DATA_W-1:0] vel,
        input logic signed [DATA_W-1:0] cpp, input logic signed [DATA_W-1:0] cpv,
        input logic signed [DATA_W-1:0] cvp, input logic signed [DATA_W-1:0] cvv,
        input logic signed [DATA_W-1:0] dt2, input logic signed [DATA_W-1:0] p00,
        input logic signed [DATA_W-1:0] p01, input logic signed [DATA_W-1:0] p10,
        input logic signed [DATA_W-1:0] p11, input logic signed [DATA_W-1:0] k0,
        input logic signed [DATA_W-1:0] k1, input logic signed [DATA_W-1:0] res,
        input logic signed [DATA_W-1:0] omk);
        logic signed [DATA_W-1:0] v;
        unique case (s)
            SRC_ZERO: v = '0;
            SRC_ONE:  v = ONE_Q24;
            SRC_Z:    v = z;
            SRC_DT:   v = {1'b0, dt};
            SRC_Q:    v = {1'b0, q};
            SRC_R:    v = {1'b0, r};
            SRC_POS:  v = pos;
            SRC_VEL:  v = vel;
            SRC_CPP:  v = cpp;
            SRC_CPV:  v = cpv;
            SRC_CVP:  v = cvp;
            SRC_CVV:  v = cvv;
            SRC_DT2:  v = dt2;
            SRC_P00:  v = p00;
            SRC_P01:  v = p01;
            SRC_P10:  v = p10;
            SRC_P11:  v = p11;
            SRC_K0:   v = k0;
            SRC_K1:   v = k1;
            SRC_RES:  v = res;
            SRC_OMK:  v = omk;
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        a_val = pick(cmd.instr.a, z_reg, dt_reg, q_reg, r_reg, pos_reg, vel_reg, cpp_reg,
                     cpv_reg, cvp_reg, cvv_reg, dt2_reg, p00_reg, p01_reg, p10_reg,
                     p11_reg, k0_reg, k1_reg, res_reg, omk_reg);
        b_val = pick(cmd.instr.b, z_reg, dt_reg, q_reg, r_reg, pos_reg, vel_reg, cpp_reg,
                     cpv_reg, cvp_reg, cvv_reg, dt2_reg, p00_reg, p01_reg, p10_reg,
                     p11_reg, k0_reg, k1_reg, res_reg, omk_reg);
        a_mag   = a_val[DATA_W-1] ? DATA_W'(-a_val) : DATA_W'(a_val);
        b_mag   = b_val[DATA_W-1] ? DATA_W'(-b_val) : DATA_W'(b_val);
        rnd_sum = prod_reg + (64'd1 << (FRAC - 1));
        term    = $signed({{(ACC_W-(64-FRAC)){1'b0}}, rnd_sum[63:FRAC]});
        st      = sat_wide(64'(acc_reg));
    end

    kcv_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.instr.op == OP_DIV),
        .den   (acc_reg),
        .num0  (p00_reg),
        .num1  (p10_reg),
        .done  (div_done),
        .q0    (dq0),
        .q1    (dq1),
        .clip  (dclip)
    );

    assign status.div_done = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg     <= TIME_STEP_RESET;
            q_reg      <= PROCESS_NOISE_RESET;
            r_reg      <= MEASUREMENT_NOISE_RESET;
            pos_reg    <= '0;
            vel_reg    <= '0;
            cpp_reg    <= ONE_Q24;
            cpv_reg    <= '0;
            cvp_reg    <= '0;
            cvv_reg    <= ONE_Q24;
            primed_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:         dt_reg <= cfg_data;
                    CFG_PROCESS_NOISE:     q_reg  <= cfg_data;
                    CFG_MEASUREMENT_NOISE: r_reg  <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.latch && (restart || !primed_reg))
            begin
                pos_reg    <= measurement;
                vel_reg    <= '0;
                primed_reg <= 1'b1;
            end
            if (cmd.instr.op == OP_STORE)
            begin
                case (cmd.instr.d)
                    SRC_POS: pos_reg <= st.val;
                    SRC_VEL: vel_reg <= st.val;
                    SRC_CPP: cpp_reg <= st.val;
                    SRC_CPV: cpv_reg <= st.val;
                    SRC_CVP: cvp_reg <= st.val;
                    SRC_CVV: cvv_reg <= st.val;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            z_reg    <= measurement;
            flag_reg <= 1'b0;
        end
        unique case (cmd.instr.op)
            OP_LOAD:  acc_reg <= ACC_W'(a_val);
            OP_ADD:   acc_reg <= acc_reg + ACC_W'(a_val);
            OP_SUB:   acc_reg <= acc_reg - ACC_W'(a_val);
            OP_MULT:
            begin
                prod_reg <= a_mag * b_mag;
                pneg_reg <= a_val[DATA_W-1] ^ b_val[DATA_W-1];
            end
            OP_MACC:  acc_reg <= pneg_reg ? acc_reg - term : acc_reg + term;
            OP_MSUB:  acc_reg <= pneg_reg ? acc_reg + term : acc_reg - term;
            OP_STORE:
            begin
                flag_reg <= flag_reg | st.clip;
                case (cmd.instr.d)
                    SRC_DT2: dt2_reg <= st.val;
                    SRC_P00: p00_reg <= st.val;
                    SRC_P01: p01_reg <= st.val;
                    SRC_P10: p10_reg <= st.val;
                    SRC_P11: p11_reg <= st.val;
                    SRC_RES: res_reg <= st.val;
                    SRC_OMK: omk_reg <= st.val;
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (div_done)
        begin
            k0_reg   <= dq0;
            k1_reg   <= dq1;
            flag_reg <= flag_reg | dclip;
        end
        if (cmd.publish)
        begin
            pe_reg <= pos_reg;
            ve_reg <= vel_reg;
            se_reg <= flag_reg;
        end
    end

    assign position_estimate = pe_reg;
    assign velocity_estimate = ve_reg;
    assign saturated         = se_reg;

endmodule
`default_nettype wire

### hdl/kcv_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcv_controller: sequencer of the Kalman filter
// Steps through the filter program and handles both channel handshakes.
// ----------------------------------------------------------------------------
module kcv_controller
    import kcv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cmd_t         cmd,
    input  wire status_t status
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RUN    = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    localparam logic [PC_W-1:0] PROG_LAST = PC_W'(61);

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;
    instr_t          fetched;

    function automatic instr_t prog(input logic [PC_W-1:0] pc);
        instr_t r;
        unique case (pc)
            6'd0:  r = '{OP_LOAD,  SRC_POS,  SRC_ZERO, SRC_ZERO};
            6'd1:  r = '{OP_MULT,  SRC_VEL,  SRC_DT,   SRC_ZERO};
            6'd2:  r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd3:  r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_POS};
            6'd4:  r = '{OP_LOAD,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd5:  r = '{OP_MULT,  SRC_DT,   SRC_DT,   SRC_ZERO};
            6'd6:  r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd7:  r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_DT2};
            6'd8:  r = '{OP_LOAD,  SRC_CPP,  SRC_ZERO, SRC_ZERO};
            6'd9:  r = '{OP_MULT,  SRC_DT,   SRC_CVP,  SRC_ZERO};
            6'd10: r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd11: r = '{OP_MULT,  SRC_DT,   SRC_CPV,  SRC_ZERO};
            6'd12: r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd13: r = '{OP_MULT,  SRC_DT2,  SRC_CVV,  SRC_ZERO};
            6'd14: r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd15: r = '{OP_ADD,   SRC_Q,    SRC_ZERO, SRC_ZERO};
            6'd16: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_P00};
            6'd17: r = '{OP_LOAD,  SRC_CPV,  SRC_ZERO, SRC_ZERO};
            6'd18: r = '{OP_MULT,  SRC_DT,   SRC_CVV,  SRC_ZERO};
            6'd19: r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd20: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_P01};
            6'd21: r = '{OP_LOAD,  SRC_CVP,  SRC_ZERO, SRC_ZERO};
            6'd22: r = '{OP_MULT,  SRC_DT,   SRC_CVV,  SRC_ZERO};
            6'd23: r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd24: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_P10};
            6'd25: r = '{OP_LOAD,  SRC_CVV,  SRC_ZERO, SRC_ZERO};
            6'd26: r = '{OP_ADD,   SRC_Q,    SRC_ZERO, SRC_ZERO};
            6'd27: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_P11};
            6'd28: r = '{OP_LOAD,  SRC_P00,  SRC_ZERO, SRC_ZERO};
            6'd29: r = '{OP_ADD,   SRC_R,    SRC_ZERO, SRC_ZERO};
            6'd30: r = '{OP_DIV,   SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd31: r = '{OP_LOAD,  SRC_Z,    SRC_ZERO, SRC_ZERO};
            6'd32: r = '{OP_SUB,   SRC_POS,  SRC_ZERO, SRC_ZERO};
            6'd33: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_RES};
            6'd34: r = '{OP_LOAD,  SRC_POS,  SRC_ZERO, SRC_ZERO};
            6'd35: r = '{OP_MULT,  SRC_K0,   SRC_RES,  SRC_ZERO};
            6'd36: r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd37: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_POS};
            6'd38: r = '{OP_LOAD,  SRC_VEL,  SRC_ZERO, SRC_ZERO};
            6'd39: r = '{OP_MULT,  SRC_K1,   SRC_RES,  SRC_ZERO};
            6'd40: r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd41: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_VEL};
            6'd42: r = '{OP_LOAD,  SRC_ONE,  SRC_ZERO, SRC_ZERO};
            6'd43: r = '{OP_SUB,   SRC_K0,   SRC_ZERO, SRC_ZERO};
            6'd44: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_OMK};
            6'd45: r = '{OP_LOAD,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd46: r = '{OP_MULT,  SRC_OMK,  SRC_P00,  SRC_ZERO};
            6'd47: r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd48: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_CPP};
            6'd49: r = '{OP_LOAD,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd50: r = '{OP_MULT,  SRC_OMK,  SRC_P01,  SRC_ZERO};
            6'd51: r = '{OP_MACC,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd52: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_CPV};
            6'd53: r = '{OP_LOAD,  SRC_P10,  SRC_ZERO, SRC_ZERO};
            6'd54: r = '{OP_MULT,  SRC_K1,   SRC_P00,  SRC_ZERO};
            6'd55: r = '{OP_MSUB,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd56: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_CVP};
            6'd57: r = '{OP_LOAD,  SRC_P11,  SRC_ZERO, SRC_ZERO};
            6'd58: r = '{OP_MULT,  SRC_K1,   SRC_P01,  SRC_ZERO};
            6'd59: r = '{OP_MSUB,  SRC_ZERO, SRC_ZERO, SRC_ZERO};
            6'd60: r = '{OP_STORE, SRC_ZERO, SRC_ZERO, SRC_CVV};
            default: r = '{OP_END, SRC_ZERO, SRC_ZERO, SRC_ZERO};
        endcase
        return r;
    endfunction

    always_comb
    begin
        fetched        = prog(pc_reg);
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '{latch: 1'b0, publish: 1'b0,
                           instr: '{OP_NOP, SRC_ZERO, SRC_ZERO, SRC_ZERO}};
        in_ready       = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    pc_next    = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (fetched.op == OP_END)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.instr = fetched;
                    if (fetched.op == OP_DIV)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_RUN;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_RUN) && (pc_reg == '0))
        else $error("accepted transfer did not start the program");
    a_div_resumes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && status.div_done) |=> (state_reg == S_RUN))
        else $error("sequencer did not resume after the division");
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("result published over a pending transfer");
    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (pc_reg <= PROG_LAST))
        else $error("program counter ran past the end");
`endif

endmodule
`default_nettype wire

### hdl/constant_velocity_kalman_filter_core.sv
// Timing: each item runs the whole filter program before its result becomes valid, plus any
// wait for the previous result to be taken. Items are processed one at a time; the run
// is set by the 61-step filter program and the 56 single-bit steps of the gain divider.
// A finished result waits in the output register while the next item is accepted.
// Reset: asynchronous, active low; restores register defaults, identity covariance
// and the unprimed state, so the first item loads position from its measurement.
`default_nettype none
// ----------------------------------------------------------------------------
// constant_velocity_kalman_filter_core: one-axis position and velocity filter
// Joins the sequencer and the datapath to the channels and the write port.
// ----------------------------------------------------------------------------
module constant_velocity_kalman_filter_core
    import kcv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    kcv_meas_if.sink              meas,
    kcv_est_if.source             est,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    kcv_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (meas.valid),
        .in_ready  (meas.ready),
        .out_valid (est.valid),
        .out_ready (est.ready),
        .cmd       (cmd),
        .status    (status)
    );

    kcv_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .measurement       (meas.measurement),
        .restart           (meas.restart),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .position_estimate (est.position_estimate),
        .velocity_estimate (est.velocity_estimate),
        .saturated         (est.saturated)
    );

endmodule
`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench of the constant-velocity Kalman filter core
// Drives measurements through the input channel, predicts each estimate with a
// fixed-point model of the filter and compares every estimate transfer in order.
// ----------------------------------------------------------------------------
module tb;
    import kcv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic               sat;
    } estimate_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    bit failed;

    kcv_meas_if meas ();
    kcv_est_if  est ();

    constant_velocity_kalman_filter_core DUT (
        .clk(clk), .rst_n(rst_n), .meas(meas.sink), .est(est.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    longint m_dt, m_q, m_r;
    longint m_pos, m_vel, m_cpp, m_cpv, m_cvp, m_cvv;
    bit     m_primed;
    bit     m_clip;
    estimate_t pending_estimates[$];

    function automatic longint clip32(longint v);
        longint hi;
        longint lo;
        hi = SAT_HI;
        lo = SAT_LO;
        if (v > hi)
        begin
            m_clip = 1;
            return hi;
        end
        if (v < lo)
        begin
            m_clip = 1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint unsigned m;
        m = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
        m = (m + (64'd1 << 23)) >> 24;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint qdiv(longint num, longint den);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        if (den == 0)
            return 0;
        n = longint'(num < 0 ? -num : num) << 24;
        d = den < 0 ? -den : den;
        q = (n + d / 2) / d;
        return clip32(((num < 0) != (den < 0)) ? -longint'(q) : longint'(q));
    endfunction

    function automatic void filter_reset();
        m_dt = TIME_STEP_RESET;
        m_q = PROCESS_NOISE_RESET;
        m_r = MEASUREMENT_NOISE_RESET;
        m_pos = 0;
        m_vel = 0;
        m_cpp = 16777216;
        m_cpv = 0;
        m_cvp = 0;
        m_cvv = 16777216;
        m_primed = 0;
    endfunction

    function automatic estimate_t filter_step(logic signed [31:0] z, logic restart);
        estimate_t e;
        longint zz, dt2, p00, p01, p10, p11, s, k0, k1, res, omk;
        zz = z;
        m_clip = 0;
        if (!m_primed || restart)
        begin
            m_pos = clip32(zz);
            m_vel = 0;
            m_primed = 1;
        end
        m_pos = clip32(m_pos + qmul(m_vel, m_dt));
        dt2 = clip32(qmul(m_dt, m_dt));
        p00 = clip32(m_cpp + qmul(m_dt, m_cvp) + qmul(m_dt, m_cpv) + qmul(dt2, m_cvv) + m_q);
        p01 = clip32(m_cpv + qmul(m_dt, m_cvv));
        p10 = clip32(m_cvp + qmul(m_dt, m_cvv));
        p11 = clip32(m_cvv + m_q);
        s = p00 + m_r;
        k0 = qdiv(p00, s);
        k1 = qdiv(p10, s);
        res = clip32(zz - m_pos);
        m_pos = clip32(m_pos + qmul(k0, res));
        m_vel = clip32(m_vel + qmul(k1, res));
        omk = clip32(64'sd16777216 - k0);
        m_cpp = clip32(qmul(omk, p00));
        m_cpv = clip32(qmul(omk, p01));
        m_cvp = clip32(p10 - qmul(k1, p00));
        m_cvv = clip32(p11 - qmul(k1, p01));
        e.pos = m_pos[31:0];
        e.vel = m_vel[31:0];
        e.sat = m_clip;
        return e;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("constant_velocity_kalman_filter_core regression: fail");
        $finish;
    end

    task automatic send_measurement(logic signed [31:0] z, logic restart);
        repeat ($urandom_range(0, 10)) @(posedge clk);
        meas.valid <= 1'b1;
        meas.measurement <= z;
        meas.restart <= restart;
        pending_estimates.insert(pending_estimates.size(), filter_step(z, restart));
        do @(posedge clk); while (!meas.ready);
        meas.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_W-1:0] value);
        wait (pending_estimates.size() == 0);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TIME_STEP:         m_dt = value;
            CFG_PROCESS_NOISE:     m_q = value;
            CFG_MEASUREMENT_NOISE: m_r = value;
            default: ;
        endcase
    endtask

    initial
    begin
        int unsigned gap;
        est.ready = 0;
        gap = $urandom_range(0, 10);
        forever
        begin
            @(posedge clk);
            if (est.valid && est.ready)
            begin
                if (pending_estimates.size() == 0)
                begin
                    $error("estimate transfer with nothing expected");
                    failed = 1;
                end
                else
                begin
                    estimate_t e;
                    e = pending_estimates.pop_front();
                    if (est.position_estimate !== e.pos)
                    begin
                        $error("position_estimate expected %0d got %0d", e.pos,
                               est.position_estimate);
                        failed = 1;
                    end
                    if (est.velocity_estimate !== e.vel)
                    begin
                        $error("velocity_estimate expected %0d got %0d", e.vel,
                               est.velocity_estimate);
                        failed = 1;
                    end
                    if (est.saturated !== e.sat)
                    begin
                        $error("saturated expected %0d got %0d", e.sat, est.saturated);
                        failed = 1;
                    end
                end
                gap = $urandom_range(0, 10);
            end
            else if (est.valid && (gap != 0))
                gap = gap - 1;
            est.ready <= (gap == 0);
        end
    end

    task automatic test_directed();
        send_measurement(32'sh7FFF_FFFF, 1'b0);
        send_measurement(32'sh8000_0000, 1'b0);
        send_measurement(32'sh8000_0000, 1'b1);
        send_measurement(32'sd0, 1'b1);
        send_measurement(32'sd65536, 1'b0);
        send_measurement(32'sd131072, 1'b0);
        send_measurement(-32'sd1, 1'b0);
        send_measurement(32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_register_extremes();
        write_register(CFG_TIME_STEP, '1);
        write_register(CFG_PROCESS_NOISE, '1);
        write_register(CFG_MEASUREMENT_NOISE, '1);
        send_measurement(32'sh7FFF_FFFF, 1'b1);
        send_measurement(32'sh8000_0000, 1'b0);
        send_measurement(32'sd0, 1'b0);
        write_register(CFG_TIME_STEP, '0);
        write_register(CFG_PROCESS_NOISE, '0);
        write_register(CFG_MEASUREMENT_NOISE, '0);
        send_measurement(32'sd1000, 1'b1);
        send_measurement(32'sd2000, 1'b0);
        send_measurement(32'sh8000_0000, 1'b0);
        send_measurement(32'sh7FFF_FFFF, 1'b0);
    endtask

    task automatic test_random_tracks(int n, int dt, int q, int r);
        logic signed [31:0] z;
        int v;
        write_register(CFG_TIME_STEP, CFG_W'(dt));
        write_register(CFG_PROCESS_NOISE, CFG_W'(q));
        write_register(CFG_MEASUREMENT_NOISE, CFG_W'(r));
        z = $urandom;
        v = $signed($urandom_range(0, 2000000)) - 1000000;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_measurement($urandom, 1'($urandom_range(0, 1)));
            else
            begin
                z = z + v + $signed($urandom_range(0, 20000)) - 10000;
                send_measurement(z, $urandom_range(0, 30) == 0);
            end
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        meas.valid = 0;
        meas.measurement = 0;
        meas.restart = 0;
        filter_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_tracks(450, TIME_STEP_RESET, PROCESS_NOISE_RESET, MEASUREMENT_NOISE_RESET);
        test_random_tracks(450, 1677721, 167772, 16777216);
        test_random_tracks(450, $urandom, $urandom_range(0, 1000000), $urandom);
        test_random_tracks(450, $urandom_range(0, 33554432), $urandom_range(0, 50000),
                           $urandom_range(0, 2000));
        wait (pending_estimates.size() == 0);
        repeat (200) @(posedge clk);
        if (!failed)
            $display("constant_velocity_kalman_filter_core regression: pass");
        else
            $display("constant_velocity_kalman_filter_core regression: fail");
        $finish;
    end
endmodule
